/* src/string_hash_bitmap_dedup_macros.svh */
// assertion macros shared by the rtl files
`ifndef STRING_HASH_BITMAP_DEDUP_MACROS_SVH
`define STRING_HASH_BITMAP_DEDUP_MACROS_SVH

`ifndef SYNTHESIS

// condition in a cycle implies a condition in the same cycle
`define SBD_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition in a cycle implies a condition in the next cycle
`define SBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define SBD_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg)
`define SBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* src/sbd_pkg.sv */
package sbd_pkg;

    localparam int unsigned HASH_MULT = 23;
    localparam logic [7:0] LOW_BOUND = 8'd65;
    localparam logic [7:0] HIGH_BOUND = 8'd122;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_SEL_W = 3;

    // status of the bit table toward the top level
    typedef struct packed {
        logic clearing;
        logic res_valid;
        logic res_is_new;
    } tbl_stat_t;

endpackage

/* src/string_hash_bitmap_dedup.sv */
// channel  | direction | handshake              | payload
// input    | in        | in_valid / in_ready    | character, has_character, end_of_string
// output   | out       | out_valid / out_ready  | is_new
//
// one beat per cycle on both sides while the output is not stalled and no clearing pass runs
// an end-of-string beat reads the bit table when it is accepted; is_new is registered
// when the pending test is taken into a free output register, which raises out_valid
// after reset a clearing pass writes all (TABLE_BITS+7)/8 table bytes, in_ready low
// a stalled output holds one result; a second pending test holds in_ready low
`include "string_hash_bitmap_dedup_macros.svh"

module string_hash_bitmap_dedup #(
    parameter int TABLE_BITS = 1048576
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sbd_pkg::BYTE_W-1:0]     character,
    input  logic                           has_character,
    input  logic                           end_of_string,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_new
);

    localparam int HW = $clog2(TABLE_BITS);

    logic [HW-1:0] running_hash_reg;
    logic [HW-1:0] running_hash_next;
    logic [HW-1:0] hash_calc;
    logic [HW-1:0] hash_upd;
    logic          counted;
    logic          in_fire;
    logic          req;
    logic          res_take;
    logic          out_valid_reg;
    logic          is_new_reg;

    sbd_pkg::tbl_stat_t stat;

    sbd_hash_unit #(
        .TABLE_BITS (TABLE_BITS)
    ) u_hash (
        .hash      (running_hash_reg),
        .character (character),
        .hash_next (hash_calc)
    );

    sbd_bit_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .req_hash (hash_upd),
        .res_take (res_take),
        .stat     (stat)
    );

    always_comb
    begin
        counted  = has_character && (character > sbd_pkg::LOW_BOUND)
                   && (character < sbd_pkg::HIGH_BOUND);
        hash_upd = counted ? hash_calc : running_hash_reg;
        res_take = stat.res_valid && (!out_valid_reg || out_ready);
        in_ready = !stat.clearing && (!stat.res_valid || res_take);
        in_fire  = in_valid && in_ready;
        req      = in_fire && end_of_string;
        if (in_fire)
        begin
            running_hash_next = end_of_string ? '0 : hash_upd;
        end
        else
        begin
            running_hash_next = running_hash_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            is_new_reg <= stat.res_is_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_new    = is_new_reg;

    `SBD_ASSERT_NEXT(a_eos_makes_pending, clk, rst_n, req, stat.res_valid, "end beat lost")
    `SBD_ASSERT_NOW(a_closed_while_clearing, clk, rst_n, stat.clearing, !in_ready, "input open during clear")
    `SBD_ASSERT_NEXT(a_take_fills_output, clk, rst_n, res_take, out_valid_reg, "result not registered")

endmodule

/* src/sbd_hash_unit.sv */
module sbd_hash_unit #(
    parameter int TABLE_BITS = 1048576
) (
    input  logic [$clog2(TABLE_BITS)-1:0]  hash,
    input  logic [sbd_pkg::BYTE_W-1:0]     character,
    output logic [$clog2(TABLE_BITS)-1:0]  hash_next
);

    localparam int    HW   = $clog2(TABLE_BITS);
    localparam longint TB  = longint'(TABLE_BITS);
    localparam longint VMAX = longint'(sbd_pkg::HASH_MULT) * (TB - 1)
                              + longint'(sbd_pkg::HIGH_BOUND) - 1;
    localparam int    VW   = $clog2(VMAX + 1);
    localparam int    QMAX = int'(VMAX / TB);

    logic [VW-1:0]   v;
    logic [QMAX+1:0] ge;
    logic [VW-1:0]   sub;
    logic [VW-1:0]   diff;

    // product plus byte, then parallel compares against every multiple of the table size
    always_comb
    begin
        v = VW'(hash) * VW'(sbd_pkg::HASH_MULT) + VW'(character);
        ge = '0;
        for (int k = 0; k <= QMAX; k++)
        begin
            ge[k] = (v >= VW'(longint'(k) * TB));
        end
        sub = '0;
        for (int k = 0; k <= QMAX; k++)
        begin
            if (ge[k] && !ge[k+1])
            begin
                sub = sub | VW'(longint'(k) * TB);
            end
        end
        diff = v - sub;
        hash_next = diff[HW-1:0];
    end

endmodule

/* src/sbd_bit_table.sv */
`include "string_hash_bitmap_dedup_macros.svh"

module sbd_bit_table #(
    parameter int TABLE_BITS = 1048576
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req,
    input  logic [$clog2(TABLE_BITS)-1:0]      req_hash,
    input  logic                               res_take,
    output sbd_pkg::tbl_stat_t                 stat
);

    localparam int HW    = $clog2(TABLE_BITS);
    localparam int DEPTH = (TABLE_BITS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = sbd_pkg::BYTE_W;
    localparam int SW    = sbd_pkg::BIT_SEL_W;

    logic [BW-1:0] mem [DEPTH];

    logic [HW+AW-1:0] req_shift;
    logic [AW-1:0]    req_addr;
    logic [SW-1:0]    req_bit;

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [AW-1:0] s1_addr_reg;
    logic [SW-1:0] s1_bit_reg;
    logic [BW-1:0] rd_data_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [BW-1:0] fwd_data_reg;

    logic [BW-1:0] old_byte;
    logic [BW-1:0] new_byte;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] wr_data;

    always_comb
    begin
        req_shift = {AW'(0), req_hash} >> SW;
        req_addr  = req_shift[AW-1:0];
        req_bit   = req_hash[SW-1:0];
    end

    // byte written in the same cycle as the read of the same entry is forwarded
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            old_byte = fwd_data_reg;
        end
        else
        begin
            old_byte = rd_data_reg;
        end
        new_byte = old_byte | BW'(BW'(1) << s1_bit_reg);
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            we      = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            we      = res_take;
            wr_addr = s1_addr_reg;
            wr_data = new_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req)
        begin
            rd_data_reg <= mem[req_addr];
        end
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req)
        begin
            s1_addr_reg  <= req_addr;
            s1_bit_reg   <= req_bit;
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_byte;
        end
    end

    always_comb
    begin
        priority if (req)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg <= s1_valid_next;
            if (req)
            begin
                fwd_valid_reg <= res_take;
            end
        end
    end

    assign stat.clearing   = clearing_reg;
    assign stat.res_valid  = s1_valid_reg;
    assign stat.res_is_new = ~old_byte[s1_bit_reg];

    `SBD_ASSERT_NOW(a_no_req_while_clearing, clk, rst_n, clearing_reg, !req, "request during clear")
    `SBD_ASSERT_NOW(a_no_req_over_pending, clk, rst_n, s1_valid_reg && !res_take, !req, "request overruns pending test")
    `SBD_ASSERT_NEXT(a_pending_holds, clk, rst_n, s1_valid_reg && !res_take, s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_bit_reg), "pending test lost")
    `SBD_ASSERT_NOW(a_take_only_pending, clk, rst_n, res_take, s1_valid_reg && !clearing_reg, "take without pending test")

endmodule
